// File: rtl/ps2r_pkg.sv
// shared constants and types for the path segment to rectangle block
package ps2r_pkg;

   localparam int COORD_BITS_DEFAULT = 32;
   localparam int QUEUE_DEPTH_DEFAULT = 2;
   localparam int POINT_BITS = 32;
   localparam int PATH_WIDTH_BITS = 31;
   localparam int LAYER_BITS = 15;
   localparam int EXT_BITS = 64;

   // per-segment classification handed from front to back
   typedef struct packed {
      logic                  vertical;
      logic                  degen;
      logic                  ext_far;
      logic                  ext_near;
      logic                  last;
      logic [LAYER_BITS-1:0] layer;
   } seg_flags_type;

   localparam int SEG_FLAGS_BITS = $bits(seg_flags_type);

endpackage

// File: rtl/ps2r_if.sv
// valid/ready channel interfaces for path points and rectangles
interface ps2r_point_if;
   import ps2r_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [POINT_BITS-1:0]      point_x;
   logic [POINT_BITS-1:0]      point_y;
   logic [PATH_WIDTH_BITS-1:0] path_width;
   logic [LAYER_BITS-1:0]      layer_number;
   logic                       last_point;

   modport source (output valid, point_x, point_y, path_width, layer_number, last_point,
                   input ready);
   modport sink (input valid, point_x, point_y, path_width, layer_number, last_point,
                 output ready);
endinterface

interface ps2r_rect_if;
   import ps2r_pkg::*;

   logic                  valid;
   logic                  ready;
   logic [POINT_BITS-1:0] left_edge;
   logic [POINT_BITS-1:0] bottom_edge;
   logic [POINT_BITS-1:0] right_edge;
   logic [POINT_BITS-1:0] top_edge;
   logic [LAYER_BITS-1:0] rect_layer;
   logic                  degenerate;
   logic                  last_rect;

   modport source (output valid, left_edge, bottom_edge, right_edge, top_edge, rect_layer,
                   degenerate, last_rect, input ready);
   modport sink (input valid, left_edge, bottom_edge, right_edge, top_edge, rect_layer,
                 degenerate, last_rect, output ready);
endinterface

// File: rtl/ps2r_front.sv
// front end: holds the previous point and classifies each closed segment
module ps2r_front #(
   parameter int COORD_BITS = ps2r_pkg::COORD_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   ps2r_point_if.sink             req,
   input  logic                   queue_full,
   output logic                   seg_push,
   output logic [COORD_BITS-1:0]  seg_x0,
   output logic [COORD_BITS-1:0]  seg_y0,
   output logic [COORD_BITS-1:0]  seg_x1,
   output logic [COORD_BITS-1:0]  seg_y1,
   output logic [COORD_BITS-1:0]  seg_half,
   output ps2r_pkg::seg_flags_type seg_flags
);
   import ps2r_pkg::*;

   logic [COORD_BITS-1:0] prev_x_ff, prev_x_in;
   logic [COORD_BITS-1:0] prev_y_ff, prev_y_in;
   logic                  have_prev_ff, have_prev_in;
   logic                  first_ff, first_in;
   logic                  accept;
   logic [EXT_BITS-1:0]   px_wide, py_wide, half_wide;
   logic [COORD_BITS-1:0] px, py;

   assign req.ready = !queue_full;
   assign accept    = req.valid && req.ready;

   // sign-extend 32-bit points, then wrap to the coordinate width
   assign px_wide   = EXT_BITS'(signed'(req.point_x));
   assign py_wide   = EXT_BITS'(signed'(req.point_y));
   assign half_wide = EXT_BITS'(req.path_width[PATH_WIDTH_BITS-1:1]);
   assign px        = px_wide[COORD_BITS-1:0];
   assign py        = py_wide[COORD_BITS-1:0];

   assign seg_push         = accept && have_prev_ff;
   assign seg_x0           = prev_x_ff;
   assign seg_y0           = prev_y_ff;
   assign seg_x1           = px;
   assign seg_y1           = py;
   assign seg_half         = half_wide[COORD_BITS-1:0];
   assign seg_flags.vertical = (px == prev_x_ff);
   assign seg_flags.degen    = (px == prev_x_ff) && (py == prev_y_ff);
   assign seg_flags.ext_far  = first_ff || !req.last_point;
   assign seg_flags.ext_near = !first_ff && req.last_point;
   assign seg_flags.last     = req.last_point;
   assign seg_flags.layer    = req.layer_number;

   always_comb begin
      prev_x_in    = prev_x_ff;
      prev_y_in    = prev_y_ff;
      have_prev_in = have_prev_ff;
      first_in     = first_ff;
      if (accept) begin
         prev_x_in    = px;
         prev_y_in    = py;
         have_prev_in = !req.last_point;
         if (req.last_point) begin
            first_in = 1'b1;
         end else if (have_prev_ff) begin
            first_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_x_ff    <= '0;
         prev_y_ff    <= '0;
         have_prev_ff <= 1'b0;
         first_ff     <= 1'b1;
      end else begin
         prev_x_ff    <= prev_x_in;
         prev_y_ff    <= prev_y_in;
         have_prev_ff <= have_prev_in;
         first_ff     <= first_in;
      end
   end

endmodule

// File: rtl/ps2r_queue.sv
// short first-in first-out queue between front and back
module ps2r_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = ps2r_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] head,
   output logic             not_empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] store_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full      = (count_ff == CW'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = store_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         store_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

// File: rtl/ps2r_back.sv
// back end: builds the grown rectangle and orders its edges
module ps2r_back #(
   parameter int COORD_BITS = ps2r_pkg::COORD_BITS_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   seg_valid,
   output logic                   seg_pop,
   input  logic [COORD_BITS-1:0]  seg_x0,
   input  logic [COORD_BITS-1:0]  seg_y0,
   input  logic [COORD_BITS-1:0]  seg_x1,
   input  logic [COORD_BITS-1:0]  seg_y1,
   input  logic [COORD_BITS-1:0]  seg_half,
   input  ps2r_pkg::seg_flags_type seg_flags,
   ps2r_rect_if.source            rsp
);
   import ps2r_pkg::*;

   // first stage: raw edges
   logic                  s1_valid_ff, s1_valid_in;
   logic [COORD_BITS-1:0] s1_l_ff, s1_r_ff, s1_b_ff, s1_t_ff;
   logic [LAYER_BITS-1:0] s1_layer_ff;
   logic                  s1_degen_ff, s1_last_ff;

   // output register
   logic                  out_valid_ff, out_valid_in;
   logic [POINT_BITS-1:0] out_l_ff, out_r_ff, out_b_ff, out_t_ff;
   logic [LAYER_BITS-1:0] out_layer_ff;
   logic                  out_degen_ff, out_last_ff;

   logic                  adv_out, adv_s1;
   logic                  fwd;
   logic [COORD_BITS-1:0] lo, hi, clo, chi, lo_ext, hi_ext, base;
   logic [COORD_BITS-1:0] l_raw, r_raw, b_raw, t_raw;
   logic [COORD_BITS-1:0] l_min, r_max, b_min, t_max;
   logic                  swap_x, swap_y;
   logic [EXT_BITS-1:0]   l_wide, r_wide, b_wide, t_wide;

   assign adv_out = !out_valid_ff || rsp.ready;
   assign adv_s1  = !s1_valid_ff || adv_out;
   assign seg_pop = seg_valid && adv_s1;

   assign s1_valid_in  = adv_s1 ? seg_valid : s1_valid_ff;
   assign out_valid_in = adv_out ? s1_valid_ff : out_valid_ff;

   always_comb begin
      if (seg_flags.vertical) begin
         fwd  = $signed(seg_y0) < $signed(seg_y1);
         lo   = fwd ? seg_y0 : seg_y1;
         hi   = fwd ? seg_y1 : seg_y0;
         base = seg_x0;
      end else begin
         fwd  = $signed(seg_x0) < $signed(seg_x1);
         lo   = fwd ? seg_x0 : seg_x1;
         hi   = fwd ? seg_x1 : seg_x0;
         base = seg_y0;
      end
      clo = base - seg_half;
      chi = base + seg_half;
      // low end is the near end on a forward segment
      lo_ext = (fwd ? seg_flags.ext_near : seg_flags.ext_far) ? lo - seg_half : lo;
      hi_ext = (fwd ? seg_flags.ext_far : seg_flags.ext_near) ? hi + seg_half : hi;
      if (seg_flags.degen) begin
         l_raw = '0;
         r_raw = '0;
         b_raw = '0;
         t_raw = '0;
      end else if (seg_flags.vertical) begin
         l_raw = clo;
         r_raw = chi;
         b_raw = lo_ext;
         t_raw = hi_ext;
      end else begin
         l_raw = lo_ext;
         r_raw = hi_ext;
         b_raw = clo;
         t_raw = chi;
      end
   end

   // wrapped sums can cross, so order the edges again
   assign swap_x = $signed(s1_r_ff) < $signed(s1_l_ff);
   assign swap_y = $signed(s1_t_ff) < $signed(s1_b_ff);
   assign l_min  = swap_x ? s1_r_ff : s1_l_ff;
   assign r_max  = swap_x ? s1_l_ff : s1_r_ff;
   assign b_min  = swap_y ? s1_t_ff : s1_b_ff;
   assign t_max  = swap_y ? s1_b_ff : s1_t_ff;
   assign l_wide = EXT_BITS'(signed'(l_min));
   assign r_wide = EXT_BITS'(signed'(r_max));
   assign b_wide = EXT_BITS'(signed'(b_min));
   assign t_wide = EXT_BITS'(signed'(t_max));

   always_ff @(posedge clock) begin
      if (adv_s1 && seg_valid) begin
         s1_l_ff     <= l_raw;
         s1_r_ff     <= r_raw;
         s1_b_ff     <= b_raw;
         s1_t_ff     <= t_raw;
         s1_layer_ff <= seg_flags.layer;
         s1_degen_ff <= seg_flags.degen;
         s1_last_ff  <= seg_flags.last;
      end
      if (adv_out && s1_valid_ff) begin
         out_l_ff     <= l_wide[POINT_BITS-1:0];
         out_r_ff     <= r_wide[POINT_BITS-1:0];
         out_b_ff     <= b_wide[POINT_BITS-1:0];
         out_t_ff     <= t_wide[POINT_BITS-1:0];
         out_layer_ff <= s1_layer_ff;
         out_degen_ff <= s1_degen_ff;
         out_last_ff  <= s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp.valid       = out_valid_ff;
   assign rsp.left_edge   = out_l_ff;
   assign rsp.right_edge  = out_r_ff;
   assign rsp.bottom_edge = out_b_ff;
   assign rsp.top_edge    = out_t_ff;
   assign rsp.rect_layer  = out_layer_ff;
   assign rsp.degenerate  = out_degen_ff;
   assign rsp.last_rect   = out_last_ff;

endmodule

// File: rtl/path_segment_to_rectangle.sv
// top level: path points in, one bounding rectangle per closed segment out
//
//  channel  dir  carries                                   handshake
//  req      in   point_x/y, path_width, layer, last_point  valid/ready
//  rsp      out  edges, rect_layer, degenerate, last_rect  valid/ready
//
// one point per cycle sustained while the queue has room; first point of a path yields no transaction
// a closing point's segment goes into the queue at the accepting edge,
// then through the edge build stage and the edge ordering stage to rsp
// req.ready drops only while the queue (two entries by default) is full
// synchronous reset empties queue and pipeline and forgets the held point
module path_segment_to_rectangle #(
   parameter int COORD_BITS  = ps2r_pkg::COORD_BITS_DEFAULT,
   parameter int QUEUE_DEPTH = ps2r_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   ps2r_point_if.sink req,
   ps2r_rect_if.source rsp
);
   import ps2r_pkg::*;

   localparam int SEG_BITS = 5 * COORD_BITS + SEG_FLAGS_BITS;

   logic                  queue_full, seg_push, seg_pop, seg_valid;
   logic [COORD_BITS-1:0] f_x0, f_y0, f_x1, f_y1, f_half;
   seg_flags_type         f_flags, b_flags;
   logic [COORD_BITS-1:0] b_x0, b_y0, b_x1, b_y1, b_half;
   logic [SEG_BITS-1:0]   push_word, head_word;

   ps2r_front #(.COORD_BITS(COORD_BITS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .queue_full (queue_full),
      .seg_push   (seg_push),
      .seg_x0     (f_x0),
      .seg_y0     (f_y0),
      .seg_x1     (f_x1),
      .seg_y1     (f_y1),
      .seg_half   (f_half),
      .seg_flags  (f_flags)
   );

   assign push_word = {f_x0, f_y0, f_x1, f_y1, f_half, f_flags};

   ps2r_queue #(.WIDTH(SEG_BITS), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (seg_push),
      .push_data (push_word),
      .full      (queue_full),
      .pop       (seg_pop),
      .head      (head_word),
      .not_empty (seg_valid)
   );

   assign {b_x0, b_y0, b_x1, b_y1, b_half, b_flags} = head_word;

   ps2r_back #(.COORD_BITS(COORD_BITS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .seg_valid (seg_valid),
      .seg_pop   (seg_pop),
      .seg_x0    (b_x0),
      .seg_y0    (b_y0),
      .seg_x1    (b_x1),
      .seg_y1    (b_y1),
      .seg_half  (b_half),
      .seg_flags (b_flags),
      .rsp       (rsp)
   );

endmodule

// File: rtl/ps2r_checker.sv
// port-level checks for the path segment to rectangle block
module ps2r_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_left_edge,
   input logic [31:0] rsp_bottom_edge,
   input logic [31:0] rsp_right_edge,
   input logic [31:0] rsp_top_edge,
   input logic        rsp_degenerate
);

   // an offered rectangle stays offered until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp valid dropped before transaction");

   // zero-length segment gives an all-zero rectangle
   a_degen_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_degenerate |-> rsp_left_edge == '0 && rsp_right_edge == '0 &&
                                      rsp_bottom_edge == '0 && rsp_top_edge == '0)
      else $error("degenerate rectangle has nonzero edges");

   // edges come out ordered as signed min and max
   a_edge_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $signed(rsp_left_edge) <= $signed(rsp_right_edge) &&
                    $signed(rsp_bottom_edge) <= $signed(rsp_top_edge))
      else $error("rectangle edges out of order");

   // nothing is offered right after reset
   a_reset_idle: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind path_segment_to_rectangle ps2r_checker u_ps2r_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp.valid),
   .rsp_ready       (rsp.ready),
   .rsp_left_edge   (rsp.left_edge),
   .rsp_bottom_edge (rsp.bottom_edge),
   .rsp_right_edge  (rsp.right_edge),
   .rsp_top_edge    (rsp.top_edge),
   .rsp_degenerate  (rsp.degenerate)
);
